// ----- rtl/ac_mains_presence_detector_core_macros.svh -----
// Assertion helpers used by the detector state module.
// Every check runs on the block clock and is off while reset is asserted.
`ifndef AC_MAINS_PRESENCE_DETECTOR_CORE_MACROS_SVH
`define AC_MAINS_PRESENCE_DETECTOR_CORE_MACROS_SVH

// Check that a property holds at every clock edge.
`define AMPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next cycle.
`define AMPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `AMPD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/acmpd_pkg.sv -----
`timescale 1ns / 1ps
package acmpd_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned AGREE_W  = 4;
  localparam int unsigned OUT_DATA_W = 8;

  // Edges closer than this are optocoupler noise
  localparam logic [TIME_W-1:0] NOISE_US = 32'd5000;

  // Register reset values
  localparam logic [TIME_W-1:0] WINDOW_MS_RST      = 32'd100;
  localparam logic [TIME_W-1:0] PULSES_NEEDED_RST  = 32'd5;
  localparam logic [TIME_W-1:0] PERIOD_LOW_US_RST  = 32'd0;
  localparam logic [TIME_W-1:0] PERIOD_HIGH_US_RST = 32'd0;

  // Agreeing windows counted before the count saturates
  localparam int unsigned AGREE_LIMIT_DEF = 10;

  typedef enum logic [0:0] {
    CMD_EDGE  = 1'b0,
    CMD_CHECK = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_MS      = 8'd0,
    REG_PULSES_NEEDED  = 8'd1,
    REG_PERIOD_LOW_US  = 8'd2,
    REG_PERIOD_HIGH_US = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic [TIME_W-1:0] window_ms;
    logic [TIME_W-1:0] pulses_needed;
    logic [TIME_W-1:0] period_low_us;
    logic [TIME_W-1:0] period_high_us;
  } cfg_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [TIME_W-1:0] time_us;
    logic [TIME_W-1:0] time_ms;
  } item_t;

  typedef struct packed {
    logic ac_present;
    logic pin_level;
    logic window_evaluated;
  } result_t;

endpackage

// ----- rtl/acmpd_state.sv -----
`timescale 1ns / 1ps
`include "ac_mains_presence_detector_core_macros.svh"
module acmpd_state #(
  parameter int unsigned AgreeLimit = acmpd_pkg::AGREE_LIMIT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  acmpd_pkg::item_t  item_i,
  input  acmpd_pkg::cfg_t   cfg_i,
  output acmpd_pkg::result_t result_o
);
  import acmpd_pkg::*;

  localparam logic [AGREE_W-1:0] AgreeMax = AGREE_W'(AgreeLimit);

  logic [TIME_W-1:0]  last_edge_q, last_edge_d;
  logic               edge_seen_q, edge_seen_d;
  logic [TIME_W-1:0]  tally_q, tally_d;
  logic [TIME_W-1:0]  last_check_q, last_check_d;
  logic               cand_q, cand_d;
  logic [AGREE_W-1:0] agree_q, agree_d;
  logic               present_q, present_d;

  logic [TIME_W-1:0]  period;
  logic [TIME_W-1:0]  since_check;
  logic               in_window;
  logic               judged;
  logic               evaluated;

  // Work out the next detector state for the item at hand
  always_comb begin
    last_edge_d  = last_edge_q;
    edge_seen_d  = edge_seen_q;
    tally_d      = tally_q;
    last_check_d = last_check_q;
    cand_d       = cand_q;
    agree_d      = agree_q;
    present_d    = present_q;
    evaluated    = 1'b0;

    period      = item_i.time_us - last_edge_q;
    since_check = item_i.time_ms - last_check_q;
    in_window   = (cfg_i.period_low_us == '0) ||
                  ((period >= cfg_i.period_low_us) && (period <= cfg_i.period_high_us));
    judged      = (tally_q >= cfg_i.pulses_needed);

    if (fire_i) begin
      case (item_i.cmd)
        CMD_EDGE: begin
          // Drop noise edges; the first edge is always taken
          if (!(edge_seen_q && (period < NOISE_US))) begin
            last_edge_d = item_i.time_us;
            edge_seen_d = 1'b1;
            if (in_window) begin
              tally_d = tally_q + 32'd1;
            end
          end
        end
        CMD_CHECK: begin
          // Close the window once the timeout has run out
          if (since_check >= cfg_i.window_ms) begin
            evaluated = 1'b1;
            tally_d   = '0;
            if (judged == cand_q) begin
              if (agree_q < AgreeMax) begin
                agree_d = agree_q + 4'd1;
              end
            end else begin
              cand_d  = judged;
              agree_d = '0;
            end
            if ((agree_d != '0) && (cand_d != present_q)) begin
              present_d = cand_d;
            end
            last_check_d = item_i.time_ms;
          end
        end
        default: ;
      endcase
    end
  end

  // Report the state as it stands after this item
  assign result_o.ac_present       = present_d;
  assign result_o.pin_level        = ~present_d;
  assign result_o.window_evaluated = evaluated;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q  <= '0;
      edge_seen_q  <= 1'b0;
      tally_q      <= '0;
      last_check_q <= '0;
      cand_q       <= 1'b0;
      agree_q      <= '0;
      present_q    <= 1'b0;
    end else begin
      last_edge_q  <= last_edge_d;
      edge_seen_q  <= edge_seen_d;
      tally_q      <= tally_d;
      last_check_q <= last_check_d;
      cand_q       <= cand_d;
      agree_q      <= agree_d;
      present_q    <= present_d;
    end
  end

  `AMPD_ASSERT(a_agree_bounded, agree_q <= AgreeMax, "agreement count above limit")
  `AMPD_ASSERT_NEXT(a_tally_cleared, fire_i && evaluated, tally_q == '0, "tally not cleared after window")
  `AMPD_ASSERT_NEXT(a_present_only_on_eval, !(fire_i && evaluated), $stable(present_q), "presence changed outside evaluation")
  `AMPD_ASSERT_NEXT(a_noise_no_change, fire_i && (item_i.cmd == CMD_EDGE) && edge_seen_q && (period < NOISE_US), $stable(tally_q) && $stable(last_edge_q), "noise edge changed state")

endmodule

// ----- rtl/ac_mains_presence_detector_core.sv -----
`timescale 1ns / 1ps
// AC mains presence detector. Each request on the input stream is either an
// optocoupler edge (tuser = 0, microsecond timestamp) or a periodic check
// (tuser = 1, millisecond timestamp), and each produces exactly one result
// carrying the presence state, the inverted pin level and whether the check
// closed a window. The block takes one request per clock cycle while its
// results are taken; a request enters an input register, and the detector
// state is updated as the request moves into the output register, where
// its result is held until taken. The output register decouples the sides:
// a new request is taken while a finished result waits.
// Configuration writes are always ready and take effect in the next cycle;
// writes to unknown indexes are ignored.
module ac_mains_presence_detector_core #(
  parameter int unsigned AgreeLimit = acmpd_pkg::AGREE_LIMIT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [31:0] time_us, [63:32] time_ms
  input  logic [2*acmpd_pkg::TIME_W-1:0]       s_axis_tdata,
  // [0] command
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] ac_present, [1] pin_level, [2] window_evaluated, [7:3] zero
  output logic [acmpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [acmpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [acmpd_pkg::TIME_W-1:0]         cfg_data_i
);
  import acmpd_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    in_valid_q, in_valid_d;
  item_t   in_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  result_t res;
  logic    advance;
  logic    s_accept;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_WINDOW_MS:      cfg_d.window_ms      = cfg_data_i;
        REG_PULSES_NEEDED:  cfg_d.pulses_needed  = cfg_data_i;
        REG_PERIOD_LOW_US:  cfg_d.period_low_us  = cfg_data_i;
        REG_PERIOD_HIGH_US: cfg_d.period_high_us = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ms      <= WINDOW_MS_RST;
      cfg_q.pulses_needed  <= PULSES_NEEDED_RST;
      cfg_q.period_low_us  <= PERIOD_LOW_US_RST;
      cfg_q.period_high_us <= PERIOD_HIGH_US_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Advance the held request whenever the output register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.cmd     <= cmd_e'(s_axis_tuser);
      in_item_q.time_us <= s_axis_tdata[TIME_W-1:0];
      in_item_q.time_ms <= s_axis_tdata[2*TIME_W-1:TIME_W];
    end
  end

  acmpd_state #(
    .AgreeLimit(AgreeLimit)
  ) u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .item_i  (in_item_q),
    .cfg_i   (cfg_q),
    .result_o(res)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_res_q.window_evaluated, out_res_q.pin_level,
                          out_res_q.ac_present};

endmodule
